/* rtl/gbdt_pkg.sv */
// Shared types, codes and constants of the graph traversal unit.
package gbdt_pkg;

    // Default number of vertex rows in the adjacency store.
    localparam int MAX_VERTICES_DEF = 32;

    // Fixed field widths.
    localparam int VCOUNT_W   = 6;
    localparam int VERT_OUT_W = 5;
    localparam int EDGE_W     = 10;

    // Vertex count after reset.
    localparam logic [VCOUNT_W-1:0] VCOUNT_RST = 6'd32;

    // Operation codes of a request beat.
    typedef enum logic [1:0] {
        OP_ADD_EDGE = 2'd0,
        OP_BFS      = 2'd1,
        OP_DFS      = 2'd2,
        OP_NOP      = 2'd3
    } op_t;

    // Status codes of a response beat.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_SELF    = 2'd2,
        ST_EXISTS  = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_SINGLE,
        S_FIND,
        S_BFS_POP,
        S_BFS_HEAD,
        S_BFS_ROW,
        S_BFS_SCAN,
        S_DFS_ROW,
        S_DFS_STEP,
        S_DFS_TOP
    } state_t;

    // Request beat.
    typedef struct packed {
        logic [1:0] operation;
        logic [5:0] source_vertex;
        logic [5:0] target_vertex;
    } req_t;

    // Response beat.
    typedef struct packed {
        logic [VERT_OUT_W-1:0] visited_vertex;
        logic [1:0]            status;
        logic [EDGE_W-1:0]     edges_total;
        logic                  last_of_run;
    } rsp_t;

endpackage

/* rtl/graph_bfs_dfs_traversal_unit.sv */
// Adjacency bit matrix with edge insertion and breadth-first or depth-first walks.
// Add edge and the unused operation: one response.
// Breadth-first walk: each vertex is dequeued, emitted with a row fetch, then its new neighbors are enqueued.
// Depth-first walk: pace set by the row read and stack read ports.
// The request side is busy for the whole walk; the response register decouples the sides.
// Reset clears the matrix through per-row valid bits at once, with no clearing pass.
module graph_bfs_dfs_traversal_unit #(
    parameter int MAX_VERTICES = gbdt_pkg::MAX_VERTICES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  gbdt_pkg::req_t                     req,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output gbdt_pkg::rsp_t                     rsp,
    input  logic                               cfg_we,
    input  logic [gbdt_pkg::VCOUNT_W-1:0]      cfg_wdata
);
    import gbdt_pkg::*;

    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int CW = 7;

    // Lowest set bit of a vertex mask.
    function automatic logic [VW-1:0] lowest_bit(input logic [MAX_VERTICES-1:0] m);
        logic [VW-1:0] idx;
        idx = '0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
            if (m[i]) begin
                idx = VW'(i);
            end
        end
        return idx;
    endfunction

    // Registers.
    state_t                    state_reg, state_next;
    logic [VCOUNT_W-1:0]       vcount_reg;
    logic [EDGE_W-1:0]         edge_cnt_reg, edge_cnt_next;
    logic [MAX_VERTICES-1:0]   visited_reg, visited_next;
    logic [MAX_VERTICES-1:0]   scan_reg, scan_next;
    logic [MAX_VERTICES-1:0]   row_vld_reg, row_vld_next;
    logic [NW-1:0]             head_reg, head_next;
    logic [NW-1:0]             tail_reg, tail_next;
    logic [NW-1:0]             emit_cnt_reg, emit_cnt_next;
    logic [VW-1:0]             top_reg, top_next;
    logic [1:0]                op_reg, op_next;
    logic [5:0]                src_reg, src_next;
    logic [5:0]                tar_reg, tar_next;
    logic                      rsp_valid_reg;
    rsp_t                      rsp_reg;

    // Memories and their read data.
    logic [MAX_VERTICES-1:0]   adj_mem [MAX_VERTICES];
    logic [VW-1:0]             pend_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0]   adj_rd_reg;
    logic                      adj_rd_vld_reg;
    logic [VW-1:0]             pend_rd_reg;

    // Memory controls.
    logic                      adj_re, adj_we, pend_re, pend_we;
    logic [VW-1:0]             adj_raddr, adj_waddr, pend_raddr, pend_waddr, pend_wdata;
    logic [MAX_VERTICES-1:0]   adj_wdata;

    // Response load.
    logic                      emit;
    rsp_t                      emit_data;

    // Shared decode.
    logic [NW-1:0]             n_act;
    logic [MAX_VERTICES-1:0]   used;
    logic [MAX_VERTICES-1:0]   row_eff;
    logic [MAX_VERTICES-1:0]   unvisited;
    logic [MAX_VERTICES-1:0]   dfs_next;
    logic [VW-1:0]             start_idx, scan_idx, dfs_idx;
    logic [NW-1:0]             tail_less2;
    logic                      slot_free;
    logic                      req_fire;
    logic                      last_emit;
    status_t                   edge_status;

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Active vertex count, clamped to the store size.
    assign n_act = (CW'(vcount_reg) > CW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(vcount_reg);

    always_comb
    begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
            used[i] = (CW'(i) < CW'(n_act));
        end
    end

    // Row as read, with rows never written reading as zero.
    assign row_eff    = adj_rd_vld_reg ? adj_rd_reg : '0;
    assign unvisited  = used & ~visited_reg;
    assign dfs_next   = row_eff & used & ~visited_reg;
    assign start_idx  = lowest_bit(unvisited);
    assign scan_idx   = lowest_bit(scan_reg);
    assign dfs_idx    = lowest_bit(dfs_next);
    assign tail_less2 = tail_reg - NW'(2);
    assign last_emit  = (emit_cnt_reg == (n_act - NW'(1)));

    // Edge check on the row of the source vertex.
    always_comb
    begin
        priority if ((CW'(src_reg) >= CW'(n_act)) || (CW'(tar_reg) >= CW'(n_act))) begin
            edge_status = ST_INVALID;
        end else if (src_reg == tar_reg) begin
            edge_status = ST_SELF;
        end else if (row_eff[tar_reg[VW-1:0]]) begin
            edge_status = ST_EXISTS;
        end else begin
            edge_status = ST_OK;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire) begin
                    if ((req.operation == OP_ADD_EDGE) || (req.operation == OP_NOP)) begin
                        state_next = S_SINGLE;
                    end else begin
                        state_next = S_FIND;
                    end
                end
            end
            S_SINGLE:
            begin
                if (slot_free) begin
                    state_next = S_IDLE;
                end
            end
            S_FIND:
            begin
                if (unvisited == '0) begin
                    state_next = S_IDLE;
                end else if (op_reg == OP_BFS) begin
                    state_next = S_BFS_POP;
                end else if (slot_free) begin
                    state_next = S_DFS_ROW;
                end
            end
            S_BFS_POP:  state_next = S_BFS_HEAD;
            S_BFS_HEAD:
            begin
                if (slot_free) begin
                    state_next = S_BFS_ROW;
                end
            end
            S_BFS_ROW:  state_next = S_BFS_SCAN;
            S_BFS_SCAN:
            begin
                if (scan_reg == '0) begin
                    state_next = (head_reg < tail_reg) ? S_BFS_POP : S_FIND;
                end
            end
            S_DFS_ROW:  state_next = S_DFS_STEP;
            S_DFS_STEP:
            begin
                if (dfs_next != '0) begin
                    if (slot_free) begin
                        state_next = S_DFS_ROW;
                    end
                end else if (tail_reg == NW'(1)) begin
                    state_next = S_FIND;
                end else begin
                    state_next = S_DFS_TOP;
                end
            end
            S_DFS_TOP:  state_next = S_DFS_ROW;
            default:    state_next = S_IDLE;
        endcase
    end

    // Datapath controls and register next values.
    always_comb
    begin
        edge_cnt_next = edge_cnt_reg;
        visited_next  = visited_reg;
        scan_next     = scan_reg;
        row_vld_next  = row_vld_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        emit_cnt_next = emit_cnt_reg;
        top_next      = top_reg;
        op_next       = op_reg;
        src_next      = src_reg;
        tar_next      = tar_reg;
        adj_re        = 1'b0;
        adj_raddr     = top_reg;
        adj_we        = 1'b0;
        adj_waddr     = src_reg[VW-1:0];
        adj_wdata     = row_eff | (MAX_VERTICES'(1) << tar_reg[VW-1:0]);
        pend_re       = 1'b0;
        pend_raddr    = head_reg[VW-1:0];
        pend_we       = 1'b0;
        pend_waddr    = tail_reg[VW-1:0];
        pend_wdata    = scan_idx;
        emit          = 1'b0;
        emit_data.visited_vertex = '0;
        emit_data.status         = ST_OK;
        emit_data.edges_total    = edge_cnt_reg;
        emit_data.last_of_run    = last_emit;

        unique case (state_reg)
            // Capture the request and fetch the source row.
            S_IDLE:
            begin
                if (req_fire) begin
                    op_next       = req.operation;
                    src_next      = req.source_vertex;
                    tar_next      = req.target_vertex;
                    adj_re        = 1'b1;
                    adj_raddr     = req.source_vertex[VW-1:0];
                    visited_next  = '0;
                    emit_cnt_next = '0;
                end
            end
            // Single response of add edge or the unused operation.
            S_SINGLE:
            begin
                if (slot_free) begin
                    emit                  = 1'b1;
                    emit_data.last_of_run = 1'b1;
                    if ((op_reg == OP_ADD_EDGE) && (edge_status == ST_OK)) begin
                        adj_we                       = 1'b1;
                        row_vld_next[src_reg[VW-1:0]] = 1'b1;
                        edge_cnt_next                = edge_cnt_reg + EDGE_W'(1);
                    end
                    if (op_reg == OP_ADD_EDGE) begin
                        emit_data.status = edge_status;
                    end
                    emit_data.edges_total = edge_cnt_next;
                end
            end
            // Start a new component from the lowest unvisited vertex.
            S_FIND:
            begin
                if ((unvisited != '0) && ((op_reg == OP_BFS) || slot_free)) begin
                    pend_we      = 1'b1;
                    pend_waddr   = '0;
                    pend_wdata   = start_idx;
                    head_next    = '0;
                    tail_next    = NW'(1);
                    visited_next = visited_reg | (MAX_VERTICES'(1) << start_idx);
                    top_next     = start_idx;
                    if (op_reg == OP_DFS) begin
                        emit                     = 1'b1;
                        emit_data.visited_vertex = VERT_OUT_W'(start_idx);
                        emit_cnt_next            = emit_cnt_reg + NW'(1);
                    end
                end
            end
            // Dequeue the head vertex.
            S_BFS_POP:
            begin
                pend_re    = 1'b1;
                pend_raddr = head_reg[VW-1:0];
                head_next  = head_reg + NW'(1);
            end
            // Emit the dequeued vertex and fetch its row.
            S_BFS_HEAD:
            begin
                if (slot_free) begin
                    emit                     = 1'b1;
                    emit_data.visited_vertex = VERT_OUT_W'(pend_rd_reg);
                    emit_cnt_next            = emit_cnt_reg + NW'(1);
                    adj_re                   = 1'b1;
                    adj_raddr                = pend_rd_reg;
                end
            end
            // Neighbors not yet visited.
            S_BFS_ROW:
            begin
                scan_next = row_eff & used & ~visited_reg;
            end
            // Enqueue one neighbor a cycle in ascending order.
            S_BFS_SCAN:
            begin
                if (scan_reg != '0) begin
                    pend_we      = 1'b1;
                    pend_waddr   = tail_reg[VW-1:0];
                    pend_wdata   = scan_idx;
                    tail_next    = tail_reg + NW'(1);
                    visited_next = visited_reg | (MAX_VERTICES'(1) << scan_idx);
                    scan_next    = scan_reg & (scan_reg - MAX_VERTICES'(1));
                end
            end
            // Fetch the row of the stack top.
            S_DFS_ROW:
            begin
                adj_re    = 1'b1;
                adj_raddr = top_reg;
            end
            // Descend to the lowest unvisited neighbor, or pop.
            S_DFS_STEP:
            begin
                if (dfs_next != '0) begin
                    if (slot_free) begin
                        pend_we                  = 1'b1;
                        pend_waddr               = tail_reg[VW-1:0];
                        pend_wdata               = dfs_idx;
                        tail_next                = tail_reg + NW'(1);
                        visited_next             = visited_reg | (MAX_VERTICES'(1) << dfs_idx);
                        top_next                 = dfs_idx;
                        emit                     = 1'b1;
                        emit_data.visited_vertex = VERT_OUT_W'(dfs_idx);
                        emit_cnt_next            = emit_cnt_reg + NW'(1);
                    end
                end else begin
                    tail_next  = tail_reg - NW'(1);
                    pend_re    = (tail_reg != NW'(1));
                    pend_raddr = tail_less2[VW-1:0];
                end
            end
            // New stack top after a pop.
            S_DFS_TOP:
            begin
                top_next = pend_rd_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            vcount_reg    <= VCOUNT_RST;
            edge_cnt_reg  <= '0;
            visited_reg   <= '0;
            row_vld_reg   <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            emit_cnt_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            edge_cnt_reg <= edge_cnt_next;
            visited_reg  <= visited_next;
            row_vld_reg  <= row_vld_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            emit_cnt_reg <= emit_cnt_next;
            if (cfg_we) begin
                vcount_reg <= cfg_wdata;
            end
            if (emit) begin
                rsp_valid_reg <= 1'b1;
            end else if (rsp_ready) begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        top_reg  <= top_next;
        op_reg   <= op_next;
        src_reg  <= src_next;
        tar_reg  <= tar_next;
        if (emit) begin
            rsp_reg <= emit_data;
        end
    end

    // Adjacency row memory with registered read.
    always_ff @(posedge clk)
    begin
        if (adj_we) begin
            adj_mem[adj_waddr] <= adj_wdata;
        end
        if (adj_re) begin
            adj_rd_reg     <= adj_mem[adj_raddr];
            adj_rd_vld_reg <= row_vld_reg[adj_raddr];
        end
    end

    // Queue and stack memory with registered read.
    always_ff @(posedge clk)
    begin
        if (pend_we) begin
            pend_mem[pend_waddr] <= pend_wdata;
        end
        if (pend_re) begin
            pend_rd_reg <= pend_mem[pend_raddr];
        end
    end

endmodule

/* rtl/gbdt_checker.sv */
// Port-level assertions for the graph traversal unit, bound to its top level.
module gbdt_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input gbdt_pkg::req_t                req,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input gbdt_pkg::rsp_t                rsp,
    input logic                          cfg_we,
    input logic [gbdt_pkg::VCOUNT_W-1:0] cfg_wdata
);
    import gbdt_pkg::*;

    // A stalled response beat holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response beat changed while stalled");

    // The block is busy in the cycle after it takes a request beat.
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken in the cycle after another");

    // An edge failure status only comes on a single-beat response.
    a_fail_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_OK) |-> rsp.last_of_run)
        else $error("failure status on a non-final beat");

    // An edge failure response carries vertex zero.
    a_fail_vertex: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_OK) |-> (rsp.visited_vertex == '0))
        else $error("failure status with a nonzero vertex");

endmodule

bind graph_bfs_dfs_traversal_unit gbdt_checker u_gbdt_checker (.*);
